FILE: rtl/paired_read_mate_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// Paired read mate matcher assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAIRED_READ_MATE_MATCHER_TOP_DEFINES_SVH
`define PAIRED_READ_MATE_MATCHER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PRMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PRMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRMM_ASSERT(lbl, prop, msg)
`define PRMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/prmm_pkg.sv
// ----------------------------------------------------------------------------
// Paired read mate matcher package
// Record, result and status types shared by the matcher modules.
// ----------------------------------------------------------------------------
package prmm_pkg;

    typedef enum logic [2:0] {
        ST_REJECT = 3'd0,
        ST_SINGLE = 3'd1,
        ST_HELD   = 3'd2,
        ST_PAIR   = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef struct packed {
        logic [31:0] target;
        logic [31:0] left;
        logic [31:0] mate;
        logic        first;
        logic        rev;
    } t_rec;

    typedef struct packed {
        t_status     status;
        logic [31:0] target;
        logic [31:0] left_pos;
        logic        left_first;
        logic        left_rev;
        logic        is_pair;
        logic [31:0] right_pos;
        logic        right_first;
        logic        right_rev;
    } t_result;

    // Per-request control broadcast to every cell
    typedef struct packed {
        logic en;      // accepted paired record, name matched
        logic hit_any; // some occupied cell matched
    } t_cell_ctl;

endpackage

FILE: rtl/prmm_cell.sv
// ----------------------------------------------------------------------------
// Open mate cell
// Holds one open record, compares it with the incoming record and shifts
// toward the head when it or an older entry is removed.
// ----------------------------------------------------------------------------
module prmm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  prmm_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  prmm_pkg::t_rec      i_rec,
    input  prmm_pkg::t_rec      i_next,
    input  logic                i_taken,
    output prmm_pkg::t_rec      o_entry,
    output logic                o_taken,
    output logic                o_hit,
    output prmm_pkg::t_rec      o_sel
);

    prmm_pkg::t_rec r_entry;
    logic           w_occupied;
    logic           w_match;

    assign w_occupied = CNT_W'(IDX) < i_count;
    assign w_match    = w_occupied
                      && (r_entry.target == i_rec.target)
                      && (r_entry.left   == i_rec.mate)
                      && (r_entry.mate   == i_rec.left)
                      && (r_entry.first  != i_rec.first)
                      && (r_entry.rev    != i_rec.rev);

    // oldest match wins: a match further up the chain masks this one
    assign o_hit   = w_match && !i_taken;
    assign o_taken = i_taken || w_match;
    assign o_entry = r_entry;
    assign o_sel   = o_hit ? r_entry : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.hit_any && o_taken) begin
                // close the gap left by the removed entry
                r_entry <= i_next;
            end else if (!i_ctl.hit_any && (CNT_W'(IDX) == i_count)) begin
                r_entry <= i_rec;
            end
        end
    end

endmodule

FILE: rtl/prmm_out_buf.sv
// ----------------------------------------------------------------------------
// Result output buffer
// Two-entry queue that parts the result side from the record side.
// ----------------------------------------------------------------------------
`include "paired_read_mate_matcher_top_defines.svh"

module prmm_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  prmm_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output prmm_pkg::t_result o_data
);

    prmm_pkg::t_result r_mem [0:1];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              w_pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    `PRMM_ASSERT(a_no_overflow, !(i_push && o_full && !w_pop), "push into full buffer")
    `PRMM_ASSERT(a_cnt_range, r_cnt != 2'd3, "buffer count out of range")
    `PRMM_ASSERT_NEXT(a_stall_holds, o_valid && i_stall && !i_push, o_valid && $stable(r_rd), "stalled result moved")

endmodule

FILE: rtl/paired_read_mate_matcher_top.sv
// ----------------------------------------------------------------------------
// Paired read mate matcher
// Pairs alignment records of one fragment against a row of open mate cells.
// ----------------------------------------------------------------------------
// One request is taken per cycle while o_stall is low and gives exactly one result.
// All OPEN_ENTRIES cells compare the incoming record in the same cycle; the
// oldest match is found along the cell chain, removed, and the younger cells
// shift up by one. Results go through a two-entry output buffer, so input is
// stalled only while that buffer holds two results that have not been taken.
// ----------------------------------------------------------------------------
`include "paired_read_mate_matcher_top_defines.svh"

module paired_read_mate_matcher_top #(
    parameter int OPEN_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_new_fragment,
    input  logic [31:0] i_name_tag,
    input  logic [31:0] i_target_id,
    input  logic [31:0] i_left_pos,
    input  logic        i_has_mate,
    input  logic [31:0] i_mate_left,
    input  logic        i_first_mate,
    input  logic        i_reversed_strand,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_target,
    output logic [31:0] o_out_left_pos,
    output logic        o_out_left_first,
    output logic        o_out_left_reversed,
    output logic        o_out_is_pair,
    output logic [31:0] o_out_right_pos,
    output logic        o_out_right_first,
    output logic        o_out_right_reversed
);

    localparam int CNT_W = $clog2(OPEN_ENTRIES + 1);

    logic [31:0]       r_name;
    logic              r_name_valid;
    logic [CNT_W-1:0]  r_count;

    logic              w_acc;
    logic              w_full_buf;
    logic              w_name_valid;
    logic              w_reject;
    logic [CNT_W-1:0]  w_eff_count;
    logic              w_take_pair;
    logic              w_tab_full;
    prmm_pkg::t_rec    w_rec;
    prmm_pkg::t_rec    w_hit_rec;
    prmm_pkg::t_cell_ctl w_ctl;
    prmm_pkg::t_result w_res;
    prmm_pkg::t_result w_out;

    prmm_pkg::t_rec    w_entry [0:OPEN_ENTRIES-1];
    prmm_pkg::t_rec    w_sel   [0:OPEN_ENTRIES-1];
    logic [OPEN_ENTRIES:0]   w_taken;
    logic [OPEN_ENTRIES-1:0] w_hit;

    assign o_stall = w_full_buf;
    assign w_acc   = i_valid && !w_full_buf;

    assign w_rec.target = i_target_id;
    assign w_rec.left   = i_left_pos;
    assign w_rec.mate   = i_mate_left;
    assign w_rec.first  = i_first_mate;
    assign w_rec.rev    = i_reversed_strand;

    // a new fragment clears the name and table before the record is judged
    assign w_name_valid = r_name_valid && !i_new_fragment;
    assign w_eff_count  = i_new_fragment ? '0 : r_count;
    assign w_reject     = w_name_valid && (r_name != i_name_tag);
    assign w_take_pair  = |w_hit;
    assign w_tab_full   = w_eff_count == CNT_W'(OPEN_ENTRIES);

    assign w_ctl.en      = w_acc && !w_reject && i_has_mate;
    assign w_ctl.hit_any = w_take_pair;

    assign w_taken[0] = 1'b0;

    for (genvar k = 0; k < OPEN_ENTRIES; k++) begin : g_cell
        prmm_pkg::t_rec w_next;
        if (k == OPEN_ENTRIES - 1) begin : g_tail
            assign w_next = w_entry[k];
        end else begin : g_body
            assign w_next = w_entry[k+1];
        end

        prmm_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (w_eff_count),
            .i_rec   (w_rec),
            .i_next  (w_next),
            .i_taken (w_taken[k]),
            .o_entry (w_entry[k]),
            .o_taken (w_taken[k+1]),
            .o_hit   (w_hit[k]),
            .o_sel   (w_sel[k])
        );
    end

    // at most one cell flags a hit, so its gated entry can be OR-ed out
    always_comb begin
        w_hit_rec = '0;
        for (int k = 0; k < OPEN_ENTRIES; k++) begin
            w_hit_rec = w_hit_rec | w_sel[k];
        end
    end

    always_comb begin
        w_res = '0;
        if (w_reject) begin
            w_res.status = prmm_pkg::ST_REJECT;
        end else if (!i_has_mate) begin
            w_res.status     = prmm_pkg::ST_SINGLE;
            w_res.target     = i_target_id;
            w_res.left_pos   = i_left_pos;
            w_res.left_first = i_first_mate;
            w_res.left_rev   = i_reversed_strand;
        end else if (w_take_pair) begin
            w_res.status  = prmm_pkg::ST_PAIR;
            w_res.target  = i_target_id;
            w_res.is_pair = 1'b1;
            // on equal positions the held reverse-strand record goes second
            if ((i_left_pos < w_hit_rec.left) ||
                ((i_left_pos == w_hit_rec.left) && w_hit_rec.rev)) begin
                w_res.left_pos    = i_left_pos;
                w_res.left_first  = i_first_mate;
                w_res.left_rev    = i_reversed_strand;
                w_res.right_pos   = w_hit_rec.left;
                w_res.right_first = w_hit_rec.first;
                w_res.right_rev   = w_hit_rec.rev;
            end else begin
                w_res.left_pos    = w_hit_rec.left;
                w_res.left_first  = w_hit_rec.first;
                w_res.left_rev    = w_hit_rec.rev;
                w_res.right_pos   = i_left_pos;
                w_res.right_first = i_first_mate;
                w_res.right_rev   = i_reversed_strand;
            end
        end else if (w_tab_full) begin
            w_res.status = prmm_pkg::ST_FULL;
        end else begin
            w_res.status = prmm_pkg::ST_HELD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name       <= '0;
            r_name_valid <= 1'b0;
            r_count      <= '0;
        end else if (w_acc && !w_reject) begin
            r_name_valid <= 1'b1;
            if (!w_name_valid) begin
                r_name <= i_name_tag;
            end
            if (!i_has_mate) begin
                r_count <= w_eff_count;
            end else if (w_take_pair) begin
                r_count <= w_eff_count - CNT_W'(1);
            end else if (!w_tab_full) begin
                r_count <= w_eff_count + CNT_W'(1);
            end else begin
                r_count <= w_eff_count;
            end
        end
    end

    prmm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_full  (w_full_buf),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_status             = w_out.status;
    assign o_out_target         = w_out.target;
    assign o_out_left_pos       = w_out.left_pos;
    assign o_out_left_first     = w_out.left_first;
    assign o_out_left_reversed  = w_out.left_rev;
    assign o_out_is_pair        = w_out.is_pair;
    assign o_out_right_pos      = w_out.right_pos;
    assign o_out_right_first    = w_out.right_first;
    assign o_out_right_reversed = w_out.right_rev;

    `PRMM_ASSERT(a_count_max, r_count <= CNT_W'(OPEN_ENTRIES), "open count above table size")
    `PRMM_ASSERT(a_hit_onehot, $onehot0(w_hit), "more than one cell claims the match")
    `PRMM_ASSERT_NEXT(a_reject_holds, w_acc && w_reject,
                      $stable(r_count) && $stable(r_name), "rejected request changed state")
    `PRMM_ASSERT_NEXT(a_pair_shrinks, w_ctl.en && w_take_pair,
                      r_count == $past(w_eff_count) - CNT_W'(1), "pair did not remove an entry")

endmodule

FILE: tb/sv/tb_paired_read_mate_matcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Paired read mate matcher testbench
// Streams read records through the matcher and predicts each result in step:
// directed corner records first, then fragments of matched, broken and noisy
// pairs under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic           new_frag;
    logic [31:0]    name;
    logic           has_mate;
    prmm_pkg::t_rec rec;
} t_read_req;

class t_mate_pair_scoreboard;
    prmm_pkg::t_rec    open_q[$];
    logic [31:0]       cur_name;
    bit                name_held;
    prmm_pkg::t_result hit_q[$];
    int                errors;
    int                table_depth;

    function new(int depth);
        table_depth = depth;
        cur_name = '0;
        name_held = 0;
        errors = 0;
    endfunction

    function prmm_pkg::t_result predict_hit(t_read_req r);
        prmm_pkg::t_result res;
        prmm_pkg::t_rec    held;
        int                idx;
        res = '0;
        idx = -1;
        if (r.new_frag) begin
            open_q.delete();
            name_held = 0;
            cur_name = '0;
        end
        if (!name_held) begin
            cur_name = r.name;
            name_held = 1;
        end else if (cur_name != r.name) begin
            res.status = prmm_pkg::ST_REJECT;
            return res;
        end
        if (!r.has_mate) begin
            res.status = prmm_pkg::ST_SINGLE;
            res.target = r.rec.target;
            res.left_pos = r.rec.left;
            res.left_first = r.rec.first;
            res.left_rev = r.rec.rev;
            return res;
        end
        // take the oldest open mate that pairs up
        foreach (open_q[i]) begin
            if (idx < 0 && open_q[i].target == r.rec.target && open_q[i].left == r.rec.mate &&
                open_q[i].mate == r.rec.left && open_q[i].first != r.rec.first &&
                open_q[i].rev != r.rec.rev)
                idx = i;
        end
        if (idx >= 0) begin
            held = open_q[idx];
            open_q.delete(idx);
            res.status = prmm_pkg::ST_PAIR;
            res.target = r.rec.target;
            res.is_pair = 1'b1;
            if (r.rec.left < held.left || (r.rec.left == held.left && held.rev)) begin
                res.left_pos = r.rec.left;
                res.left_first = r.rec.first;
                res.left_rev = r.rec.rev;
                res.right_pos = held.left;
                res.right_first = held.first;
                res.right_rev = held.rev;
            end else begin
                res.left_pos = held.left;
                res.left_first = held.first;
                res.left_rev = held.rev;
                res.right_pos = r.rec.left;
                res.right_first = r.rec.first;
                res.right_rev = r.rec.rev;
            end
            return res;
        end
        if (open_q.size() >= table_depth) begin
            res.status = prmm_pkg::ST_FULL;
            return res;
        end
        open_q.insert(open_q.size(), r.rec);
        res.status = prmm_pkg::ST_HELD;
        return res;
    endfunction

    function void note_request(t_read_req r);
        hit_q.insert(hit_q.size(), predict_hit(r));
    endfunction

    function void check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, got_v);
        end
    endfunction

    function void check_result(prmm_pkg::t_result got);
        prmm_pkg::t_result exp_r;
        if (hit_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, expected none actual status %0d",
                     $time, got.status);
            return;
        end
        exp_r = hit_q.pop_front();
        check_field("status", 32'(exp_r.status), 32'(got.status));
        check_field("out_target", exp_r.target, got.target);
        check_field("out_left_pos", exp_r.left_pos, got.left_pos);
        check_field("out_left_first", 32'(exp_r.left_first), 32'(got.left_first));
        check_field("out_left_reversed", 32'(exp_r.left_rev), 32'(got.left_rev));
        check_field("out_is_pair", 32'(exp_r.is_pair), 32'(got.is_pair));
        check_field("out_right_pos", exp_r.right_pos, got.right_pos);
        check_field("out_right_first", 32'(exp_r.right_first), 32'(got.right_first));
        check_field("out_right_reversed", 32'(exp_r.right_rev), 32'(got.right_rev));
    endfunction

    function int pending();
        return hit_q.size();
    endfunction
endclass

module tb_paired_read_mate_matcher_top;

    localparam int OPEN_ENTRIES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 140;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_new_fragment;
    logic [31:0] i_name_tag;
    logic [31:0] i_target_id;
    logic [31:0] i_left_pos;
    logic        i_has_mate;
    logic [31:0] i_mate_left;
    logic        i_first_mate;
    logic        i_reversed_strand;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_out_target;
    logic [31:0] o_out_left_pos;
    logic        o_out_left_first;
    logic        o_out_left_reversed;
    logic        o_out_is_pair;
    logic [31:0] o_out_right_pos;
    logic        o_out_right_first;
    logic        o_out_right_reversed;

    t_mate_pair_scoreboard sb = new(OPEN_ENTRIES);
    int gap_pct   = 0;
    int stall_pct = 0;
    int sent_items = 0;
    int cycle_count = 0;

    paired_read_mate_matcher_top #(
        .OPEN_ENTRIES(OPEN_ENTRIES)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_new_fragment      (i_new_fragment),
        .i_name_tag          (i_name_tag),
        .i_target_id         (i_target_id),
        .i_left_pos          (i_left_pos),
        .i_has_mate          (i_has_mate),
        .i_mate_left         (i_mate_left),
        .i_first_mate        (i_first_mate),
        .i_reversed_strand   (i_reversed_strand),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_out_target        (o_out_target),
        .o_out_left_pos      (o_out_left_pos),
        .o_out_left_first    (o_out_left_first),
        .o_out_left_reversed (o_out_left_reversed),
        .o_out_is_pair       (o_out_is_pair),
        .o_out_right_pos     (o_out_right_pos),
        .o_out_right_first   (o_out_right_first),
        .o_out_right_reversed(o_out_right_reversed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[paired_read_mate_matcher_top] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // note accepted requests before checking results of the same edge
    always @(posedge i_clk) begin
        t_read_req         req;
        prmm_pkg::t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                req.new_frag = i_new_fragment;
                req.name = i_name_tag;
                req.has_mate = i_has_mate;
                req.rec.target = i_target_id;
                req.rec.left = i_left_pos;
                req.rec.mate = i_mate_left;
                req.rec.first = i_first_mate;
                req.rec.rev = i_reversed_strand;
                sb.note_request(req);
            end
            if (o_valid && !i_stall) begin
                got.status = prmm_pkg::t_status'(o_status);
                got.target = o_out_target;
                got.left_pos = o_out_left_pos;
                got.left_first = o_out_left_first;
                got.left_rev = o_out_left_reversed;
                got.is_pair = o_out_is_pair;
                got.right_pos = o_out_right_pos;
                got.right_first = o_out_right_first;
                got.right_rev = o_out_right_reversed;
                sb.check_result(got);
            end
        end
    end

    function automatic t_read_req make_req(logic nf, logic [31:0] nm, logic [31:0] tg,
                                           logic [31:0] lp, logic hm, logic [31:0] ml,
                                           logic fm, logic rv);
        t_read_req r;
        r.new_frag = nf;
        r.name = nm;
        r.has_mate = hm;
        r.rec.target = tg;
        r.rec.left = lp;
        r.rec.mate = ml;
        r.rec.first = fm;
        r.rec.rev = rv;
        return r;
    endfunction

    function automatic void shuffle_reqs(ref t_read_req q[$]);
        t_read_req tmp;
        int j;
        for (int i = q.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = q[i];
            q[i] = q[j];
            q[j] = tmp;
        end
    endfunction

    task automatic send_request(input t_read_req r);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_new_fragment <= r.new_frag;
        i_name_tag <= r.name;
        i_target_id <= r.rec.target;
        i_left_pos <= r.rec.left;
        i_has_mate <= r.has_mate;
        i_mate_left <= r.rec.mate;
        i_first_mate <= r.rec.first;
        i_reversed_strand <= r.rec.rev;
        do @(posedge i_clk); while (o_stall);
        sent_items++;
    endtask

    // hold the sender until every predicted result has been taken
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_fragment();
        t_read_req   frag_q[$];
        t_read_req   b_q[$];
        t_read_req   a;
        t_read_req   b;
        t_read_req   tmp;
        logic [31:0] name;
        logic [31:0] tgt;
        bit          narrow;
        int          kind;
        int          n;
        name = $urandom;
        narrow = 1'($urandom_range(1));
        tgt = narrow ? 32'($urandom_range(3)) : 32'($urandom);
        kind = $urandom_range(99);
        if (kind < 15) begin
            // overfill the open table, then send the mates in random order
            n = OPEN_ENTRIES + $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                a = make_req(i == 0, name, tgt, 32'(i), 1'b1, 32'(100 + i),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                frag_q.insert(frag_q.size(), a);
                b_q.insert(b_q.size(), make_req(1'b0, name, tgt, 32'(100 + i), 1'b1, 32'(i),
                                                !a.rec.first, !a.rec.rev));
            end
            shuffle_reqs(b_q);
            frag_q = {frag_q, b_q};
        end else if (kind < 30) begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) begin
                frag_q.insert(frag_q.size(),
                              make_req($urandom_range(9) == 0,
                                       ($urandom_range(3) == 0) ? 32'($urandom) : name,
                                       32'($urandom_range(1)), $urandom_range(3),
                                       1'($urandom_range(1)), $urandom_range(3),
                                       1'($urandom_range(1)), 1'($urandom_range(1))));
            end
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                a = make_req(1'b0, name, tgt,
                             narrow ? 32'($urandom_range(15)) : 32'($urandom), 1'b1,
                             narrow ? 32'($urandom_range(15)) : 32'($urandom),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                b = make_req(1'b0, name, tgt, a.rec.mate, 1'b1, a.rec.left,
                             !a.rec.first, !a.rec.rev);
                if ($urandom_range(99) < 20) begin
                    case ($urandom_range(3))
                        0: b.rec.target = b.rec.target ^ 32'h1;
                        1: b.rec.mate = b.rec.mate + 32'h1;
                        2: b.rec.first = a.rec.first;
                        default: b.rec.rev = a.rec.rev;
                    endcase
                end
                frag_q.insert(frag_q.size(), a);
                frag_q.insert(frag_q.size(), b);
                if ($urandom_range(99) < 15) frag_q.insert(frag_q.size(), a);
            end
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) begin
                frag_q.insert(frag_q.size(),
                              make_req(1'b0, name, tgt, $urandom, 1'b0, $urandom,
                                       1'($urandom_range(1)), 1'($urandom_range(1))));
            end
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) begin
                frag_q.insert(frag_q.size(),
                              make_req(1'b0, name ^ (32'h1 << $urandom_range(31)), tgt,
                                       $urandom, 1'($urandom_range(1)), $urandom,
                                       1'($urandom_range(1)), 1'($urandom_range(1))));
            end
            shuffle_reqs(frag_q);
            // open the fragment with a record that carries its own name
            foreach (frag_q[i]) begin
                if (frag_q[i].name == name) begin
                    tmp = frag_q[0];
                    frag_q[0] = frag_q[i];
                    frag_q[i] = tmp;
                    break;
                end
            end
            frag_q[0].new_frag = ($urandom_range(9) != 0);
        end
        foreach (frag_q[i]) send_request(frag_q[i]);
    endtask

    initial begin
        int          start_items;
        logic [31:0] tag;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_new_fragment <= 1'b0;
        i_name_tag <= '0;
        i_target_id <= '0;
        i_left_pos <= '0;
        i_has_mate <= 1'b0;
        i_mate_left <= '0;
        i_first_mate <= 1'b0;
        i_reversed_strand <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no name yet, all-ones single-end record, then a foreign name
        send_request(make_req(1'b0, '1, '1, '1, 1'b0, '1, 1'b1, 1'b1));
        send_request(make_req(1'b0, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        // equal positions: forward held record stays left, reverse one goes right
        send_request(make_req(1'b1, '0, '0, '0, 1'b1, '0, 1'b0, 1'b0));
        send_request(make_req(1'b0, '0, '0, '0, 1'b1, '0, 1'b1, 1'b1));
        send_request(make_req(1'b0, '0, '1, 32'd5, 1'b1, 32'd5, 1'b1, 1'b1));
        send_request(make_req(1'b0, '0, '1, 32'd5, 1'b1, 32'd5, 1'b0, 1'b0));
        // fill the table, overflow it, then close a gap in the middle
        tag = 32'hA5A5_5A5A;
        for (int i = 0; i < OPEN_ENTRIES; i++)
            send_request(make_req(i == 0, tag, 32'd7, 32'(1000 + i), 1'b1, 32'(2000 + i),
                                  1'b0, 1'b1));
        send_request(make_req(1'b0, tag, 32'd7, 32'd3000, 1'b1, 32'd3001, 1'b0, 1'b0));
        send_request(make_req(1'b0, tag, 32'd7, 32'd2003, 1'b1, 32'd1003, 1'b1, 1'b0));
        send_request(make_req(1'b0, tag, 32'd7, 32'd9, 1'b0, 32'd9, 1'b1, 1'b0));
        wait_for_results();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    gap_pct = 72;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 72;
                end
                3: begin
                    gap_pct = 14;
                    stall_pct = 14;
                end
                default: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            start_items = sent_items;
            while (sent_items - start_items < PHASE_ITEMS) run_fragment();
            wait_for_results();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[paired_read_mate_matcher_top] OK");
        end else begin
            $display("[paired_read_mate_matcher_top] ERROR");
        end
        $finish;
    end

endmodule
